FILE: rtl/mplq_pkg.sv
// Package for the min-priority LIFO queue: command and result codes,
// controller states and the control and status structs between controller and datapath.
// No dependencies.
package mplq_pkg;

  localparam int NUM_PRIORITIES_DEF = 64;
  localparam int SLOTS_DEF          = 256;
  localparam int HANDLE_BITS_DEF    = 16;

  localparam int PRIO_IN_W = 6;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 9;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic need_fetch;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/mplq_ctrl.sv
// Controller of the min-priority LIFO queue: sequences accept, slot fetch and commit.
// Depends on mplq_pkg.
module mplq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mplq_pkg::sts_t sts,
  output mplq_pkg::ctl_t ctl
);
  import mplq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = sts.need_fetch ? S_FETCH : S_COMMIT;
        end
      end
      S_FETCH: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = rst || (state != S_IDLE);
    ctl.accept = !rst && (state == S_IDLE) && in_valid;
    ctl.fetch  = (state == S_FETCH);
    ctl.commit = (state == S_COMMIT) && sts.out_free;
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |=> (state != S_IDLE))
    else $error("controller stayed idle after accepting a request");
  a_fetch_then_commit: assert property (@(posedge clk) disable iff (rst)
    ctl.fetch |=> (state == S_COMMIT))
    else $error("slot fetch not followed by commit");
  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> sts.out_free)
    else $error("commit while result register blocked");
`endif

endmodule

FILE: rtl/mplq_dp.sv
// Datapath of the min-priority LIFO queue: bucket and slot memories, free-slot stack,
// counters, priority search and result register. Depends on mplq_pkg.
module mplq_dp #(
  parameter int NUM_PRIORITIES = mplq_pkg::NUM_PRIORITIES_DEF,
  parameter int SLOTS          = mplq_pkg::SLOTS_DEF,
  parameter int HANDLE_BITS    = mplq_pkg::HANDLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mplq_pkg::ctl_t                    ctl,
  output mplq_pkg::sts_t                    sts,
  input  logic                              command,
  input  logic [mplq_pkg::PRIO_IN_W-1:0]    priority_req,
  input  logic [HANDLE_BITS-1:0]            entry_handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mplq_pkg::STATUS_W-1:0]     status,
  output logic [HANDLE_BITS-1:0]            out_handle,
  output logic [mplq_pkg::PRIO_IN_W-1:0]    out_priority,
  output logic [mplq_pkg::COUNT_W-1:0]      stored_count
);
  import mplq_pkg::*;

  localparam int PRIO_W = $clog2(NUM_PRIORITIES);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  logic [SLOT_W-1:0]      bucket_top   [NUM_PRIORITIES];
  logic [CNT_W-1:0]       bucket_depth [NUM_PRIORITIES];
  logic [HANDLE_BITS-1:0] slot_handle  [SLOTS];
  logic [SLOT_W-1:0]      slot_below   [SLOTS];
  logic [SLOT_W-1:0]      free_slots   [SLOTS];

  logic [NUM_PRIORITIES-1:0] bucket_nonempty;
  logic [CNT_W-1:0]          free_top;
  logic [CNT_W-1:0]          fresh_slots;
  logic [CNT_W-1:0]          entry_total;

  logic                   op_pop;
  logic                   op_skip;
  logic [PRIO_W-1:0]      op_prio;
  logic [HANDLE_BITS-1:0] op_handle;

  logic [SLOT_W-1:0]      top_rd;
  logic [CNT_W-1:0]       depth_rd;
  logic [SLOT_W-1:0]      free_rd;
  logic [HANDLE_BITS-1:0] handle_rd;
  logic [SLOT_W-1:0]      below_rd;

  logic                   enc_found;
  logic [PRIO_W-1:0]      enc_idx;
  logic [PRIO_W-1:0]      prio_sat;
  logic                   is_full;
  logic [PRIO_W-1:0]      rd_prio;
  logic [SLOT_W-1:0]      free_rd_addr;

  logic                   was_nonempty;
  logic                   use_free;
  logic [SLOT_W-1:0]      push_slot;
  logic [CNT_W-1:0]       depth_inc;
  logic [CNT_W-1:0]       depth_dec;
  logic                   do_push;
  logic                   do_pop;
  logic                   free_room;
  logic [CNT_W-1:0]       total_next;

  always_comb begin
    enc_idx = '0;
    for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
      if (bucket_nonempty[i]) begin
        enc_idx = PRIO_W'(i);
      end
    end
  end

  always_comb begin
    enc_found    = |bucket_nonempty;
    prio_sat     = (32'(priority_req) >= NUM_PRIORITIES) ? PRIO_W'(NUM_PRIORITIES - 1)
                                                         : PRIO_W'(priority_req);
    is_full      = (32'(entry_total) >= SLOTS);
    rd_prio      = (command == CMD_POP) ? enc_idx : prio_sat;
    free_rd_addr = (free_top == '0) ? '0 : SLOT_W'(free_top - 1'b1);

    was_nonempty = bucket_nonempty[op_prio];
    use_free     = (free_top != '0);
    push_slot    = use_free ? free_rd : fresh_slots[SLOT_W-1:0];
    depth_inc    = was_nonempty ? depth_rd + 1'b1 : CNT_W'(1);
    depth_dec    = (depth_rd != '0) ? depth_rd - 1'b1 : '0;
    do_push      = ctl.commit && !op_pop && !op_skip;
    do_pop       = ctl.commit && op_pop && !op_skip;
    free_room    = (32'(free_top) < SLOTS);

    if (do_push) begin
      total_next = entry_total + 1'b1;
    end else if (do_pop && (entry_total != '0)) begin
      total_next = entry_total - 1'b1;
    end else begin
      total_next = entry_total;
    end

    sts.need_fetch = (command == CMD_POP) && enc_found;
    sts.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_pop    <= (command == CMD_POP);
      op_skip   <= (command == CMD_POP) ? !enc_found : is_full;
      op_prio   <= rd_prio;
      op_handle <= entry_handle;
      top_rd    <= bucket_top[rd_prio];
      depth_rd  <= bucket_depth[rd_prio];
      free_rd   <= free_slots[free_rd_addr];
    end
    if (ctl.fetch) begin
      handle_rd <= slot_handle[top_rd];
      below_rd  <= slot_below[top_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_handle[push_slot]  <= op_handle;
      slot_below[push_slot]   <= was_nonempty ? top_rd : '0;
      bucket_top[op_prio]     <= push_slot;
      bucket_depth[op_prio]   <= depth_inc;
    end else if (do_pop) begin
      bucket_top[op_prio]     <= below_rd;
      bucket_depth[op_prio]   <= depth_dec;
      if (free_room) begin
        free_slots[free_top[SLOT_W-1:0]] <= top_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_nonempty <= '0;
      free_top        <= '0;
      fresh_slots     <= '0;
      entry_total     <= '0;
    end else begin
      entry_total <= total_next;
      if (do_push) begin
        bucket_nonempty[op_prio] <= 1'b1;
        if (use_free) begin
          free_top <= free_top - 1'b1;
        end else begin
          fresh_slots <= fresh_slots + 1'b1;
        end
      end else if (do_pop) begin
        bucket_nonempty[op_prio] <= (depth_dec != '0);
        if (free_room) begin
          free_top <= free_top + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      priority case (1'b1)
        op_skip && op_pop: status <= ST_EMPTY;
        op_skip:           status <= ST_FULL;
        op_pop:            status <= ST_POPPED;
        default:           status <= ST_PUSHED;
      endcase
      out_handle   <= do_pop ? handle_rd : '0;
      out_priority <= do_pop ? PRIO_IN_W'(op_prio) : '0;
      stored_count <= COUNT_W'(total_next);
    end
  end

`ifndef SYNTHESIS
  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(entry_total) <= SLOTS)
    else $error("stored count exceeds slot store");
  a_slot_accounting: assert property (@(posedge clk) disable iff (rst)
    (32'(fresh_slots) == 32'(entry_total) + 32'(free_top)))
    else $error("slot accounting broken: used slots differ from held plus free");
  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    ((bucket_nonempty == '0) == (entry_total == '0)))
    else $error("bucket flags disagree with stored count");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && !ctl.commit) |=> out_valid)
    else $error("stalled result dropped");
`endif

endmodule

FILE: rtl/min_priority_lifo_queue.sv
// Top level of the min-priority LIFO queue: joins the controller and the datapath.
// Depends on mplq_pkg, mplq_ctrl and mplq_dp.
//
// Usage: each request on the input channel (in_valid, in_stall) is a push
// (command 0: store entry_handle under priority_req) or a pop (command 1:
// return the newest entry of the smallest nonempty priority). Every request
// produces exactly one result on the output channel (out_valid, out_stall)
// with a status, the popped handle and priority, and the count held after it.
// A push, a push while full and a pop while empty go from accept straight
// to commit; a pop that finds an entry passes a fetch state between them,
// for the dependent read of the slot memories through the bucket head.
// The result register is loaded at the end of the request; in_stall stays
// high while a request is in work. If the receiver stalls, the result waits
// in its register and a finished request is held at commit until the
// register frees, so no result is lost. Reset clears the bucket flags and
// counters; the block takes a request in the first cycle after reset.
module min_priority_lifo_queue #(
  parameter int NUM_PRIORITIES = mplq_pkg::NUM_PRIORITIES_DEF,
  parameter int SLOTS          = mplq_pkg::SLOTS_DEF,
  parameter int HANDLE_BITS    = mplq_pkg::HANDLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [mplq_pkg::PRIO_IN_W-1:0] priority_req,
  input  logic [HANDLE_BITS-1:0]         entry_handle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mplq_pkg::STATUS_W-1:0]  status,
  output logic [HANDLE_BITS-1:0]         out_handle,
  output logic [mplq_pkg::PRIO_IN_W-1:0] out_priority,
  output logic [mplq_pkg::COUNT_W-1:0]   stored_count
);
  import mplq_pkg::*;

  ctl_t ctl;
  sts_t sts;

  mplq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  mplq_dp #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .SLOTS          (SLOTS),
    .HANDLE_BITS    (HANDLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .command      (command),
    .priority_req (priority_req),
    .entry_handle (entry_handle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_handle   (out_handle),
    .out_priority (out_priority),
    .stored_count (stored_count)
  );

endmodule
